@@ rtl/spp_pkg.sv @@
// ----------------------------------------------------------------------------
// spp_pkg
// shared widths, codes, request type and the quarter-sine gain table for the
// slewed constant-power panner
// ----------------------------------------------------------------------------
package spp_pkg;

	localparam int PAN_FRAC_BITS     = 22;
	localparam int PAN_W             = 24;
	localparam int MAX_BUFFER_FRAMES = 4096;
	localparam int N_W               = 13;
	localparam int RATE_W            = 20;
	localparam int AMT_W             = RATE_W + N_W;
	localparam int SLEW_W            = AMT_W + 3;
	localparam int SAMPLE_W          = 16;
	localparam int GAIN_W            = 16;
	localparam int SINE_LOG2         = 8;
	localparam int SINE_ENTRIES      = 1 << SINE_LOG2;
	localparam int FRAC_W            = PAN_FRAC_BITS + 1 - SINE_LOG2;
	localparam int SINE_IDX_W        = PAN_W - FRAC_W;
	localparam int QUEUE_DEPTH       = 4;
	localparam int ADDR_W            = 4;
	localparam int DATA_W            = 32;

	localparam logic signed [PAN_W-1:0]    PAN_ONE    = PAN_W'(1 << PAN_FRAC_BITS);
	localparam logic [N_W-1:0]             N_MAX      = N_W'(MAX_BUFFER_FRAMES);
	localparam logic [GAIN_W-1:0]          GAIN_RESET = 16'd23170;
	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7fff;
	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

	localparam logic [RATE_W-1:0] MANUAL_FADE_RESET = 20'd34953;
	localparam logic [RATE_W-1:0] ATTACK_RESET      = 20'd1748;
	localparam logic [RATE_W-1:0] DECAY_RESET       = 20'd87;

	// request function codes
	localparam logic [2:0] FUNC_SET_MANUAL = 3'd0;
	localparam logic [2:0] FUNC_SET_ADJUST = 3'd1;
	localparam logic [2:0] FUNC_SET_FLAG   = 3'd2;
	localparam logic [2:0] FUNC_BUFFER     = 3'd3;
	localparam logic [2:0] FUNC_FRAME      = 3'd4;

	// classified request kinds
	localparam logic [2:0] KIND_NONE       = 3'd0;
	localparam logic [2:0] KIND_SET_MANUAL = 3'd1;
	localparam logic [2:0] KIND_SET_ADJUST = 3'd2;
	localparam logic [2:0] KIND_SET_FLAG   = 3'd3;
	localparam logic [2:0] KIND_BUFFER     = 3'd4;
	localparam logic [2:0] KIND_FRAME      = 3'd5;

	// register indexes
	localparam logic [1:0] REG_MANUAL_FADE = 2'd0;
	localparam logic [1:0] REG_ATTACK      = 2'd1;
	localparam logic [1:0] REG_DECAY       = 2'd2;

	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
	localparam longint unsigned TAYLOR_DIV [1:7] = '{6, 20, 42, 72, 110, 156, 210};

	typedef struct packed {
		logic [2:0]                   kind;
		logic signed [PAN_W-1:0]      pan;
		logic                         flag;
		logic [N_W-1:0]               frames;
		logic signed [SAMPLE_W-1:0]   left;
		logic signed [SAMPLE_W-1:0]   right;
	} item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	typedef struct packed {
		logic [RATE_W-1:0] manual_fade;
		logic [RATE_W-1:0] attack;
		logic [RATE_W-1:0] decay;
	} rates_t;

	typedef logic [GAIN_W-1:0] sine_tab_t [0:SINE_ENTRIES];

	// round(32768*sin(k*pi/(2*entries))) by a Q30 Taylor series
	function automatic sine_tab_t build_sine();
		sine_tab_t         tab;
		longint unsigned   x;
		longint unsigned   x2;
		longint unsigned   term;
		longint            sum;
		for (int k = 0; k <= SINE_ENTRIES; k++) begin
			x = (longint'(k) * HALF_PI_Q30 + SINE_ENTRIES / 2) / SINE_ENTRIES;
			x2 = (x * x) >> 30;
			term = x;
			sum = longint'(x);
			for (int n = 1; n <= 7; n++) begin
				term = ((term * x2) >> 30) / TAYLOR_DIV[n];
				if (n % 2 == 1) begin
					sum = sum - longint'(term);
				end else begin
					sum = sum + longint'(term);
				end
			end
			if (sum < 0) begin
				sum = 0;
			end
			sum = (sum + 16384) >>> 15;
			if (sum > 32768) begin
				sum = 32768;
			end
			tab[k] = GAIN_W'(sum);
		end
		return tab;
	endfunction

endpackage

@@ rtl/spp_front.sv @@
// ----------------------------------------------------------------------------
// spp_front
// input register: accepts requests, classifies the function code and limits
// the frame count before handing them to the queue
// ----------------------------------------------------------------------------
module spp_front (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic [2:0]                             func,
	input  logic signed [spp_pkg::PAN_W-1:0]       pan_value,
	input  logic                                   adjust_on,
	input  logic [spp_pkg::N_W-1:0]                frame_count,
	input  logic signed [spp_pkg::SAMPLE_W-1:0]    left_in,
	input  logic signed [spp_pkg::SAMPLE_W-1:0]    right_in,
	input  spp_pkg::q_stat_t                       q_stat,
	output logic                                   push,
	output spp_pkg::item_t                         item
);

	logic           valid_s1;
	spp_pkg::item_t item_s1;
	spp_pkg::item_t item_d;

	assign in_stall = valid_s1 && q_stat.full;
	assign push     = valid_s1 && !q_stat.full;
	assign item     = item_s1;

	always_comb begin
		item_d.pan    = pan_value;
		item_d.flag   = adjust_on;
		item_d.frames = (frame_count > spp_pkg::N_MAX) ? spp_pkg::N_MAX : frame_count;
		item_d.left   = left_in;
		item_d.right  = right_in;
		case (func)
			spp_pkg::FUNC_SET_MANUAL: item_d.kind = spp_pkg::KIND_SET_MANUAL;
			spp_pkg::FUNC_SET_ADJUST: item_d.kind = spp_pkg::KIND_SET_ADJUST;
			spp_pkg::FUNC_SET_FLAG:   item_d.kind = spp_pkg::KIND_SET_FLAG;
			spp_pkg::FUNC_BUFFER:     item_d.kind = spp_pkg::KIND_BUFFER;
			spp_pkg::FUNC_FRAME:      item_d.kind = spp_pkg::KIND_FRAME;
			default:                  item_d.kind = spp_pkg::KIND_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= item_d;
		end
	end

endmodule

@@ rtl/spp_queue.sv @@
// ----------------------------------------------------------------------------
// spp_queue
// short request queue between the front and the executing side
// ----------------------------------------------------------------------------
module spp_queue #(
	parameter int QUEUE_DEPTH = spp_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  spp_pkg::item_t   wr_item,
	input  logic             pop,
	output spp_pkg::item_t   rd_item,
	output spp_pkg::q_stat_t stat
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	spp_pkg::item_t   mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign stat.full  = (count_q == CNT_W'(QUEUE_DEPTH));
	assign stat.empty = (count_q == '0);
	assign rd_item    = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

endmodule

@@ rtl/spp_back.sv @@
// ----------------------------------------------------------------------------
// spp_back
// executing side: holds the pan state, runs the buffer-start sequence
// (rate multiply, slew and clamp, table read, interpolation), scales frames
// and drives the result register
// ----------------------------------------------------------------------------
module spp_back (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  spp_pkg::rates_t                        rates,
	input  spp_pkg::q_stat_t                       q_stat,
	input  spp_pkg::item_t                         item,
	output logic                                   pop,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic signed [spp_pkg::SAMPLE_W-1:0]    left_out,
	output logic signed [spp_pkg::SAMPLE_W-1:0]    right_out,
	output logic signed [spp_pkg::PAN_W-1:0]       pan_now,
	output logic                                   frame_valid
);

	localparam int PAN_W   = spp_pkg::PAN_W;
	localparam int GAIN_W  = spp_pkg::GAIN_W;
	localparam int FRAC_W  = spp_pkg::FRAC_W;
	localparam int IDX_W   = spp_pkg::SINE_IDX_W;
	localparam int SLEW_W  = spp_pkg::SLEW_W;
	localparam int AMT_W   = spp_pkg::AMT_W;
	localparam int SMP_W   = spp_pkg::SAMPLE_W;
	localparam int IP_W    = GAIN_W + FRAC_W;

	localparam int LANE_LEFT  = 0;
	localparam int LANE_RIGHT = 1;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_MUL    = 3'd1;
	localparam logic [2:0] ST_SLEW   = 3'd2;
	localparam logic [2:0] ST_LOOK   = 3'd3;
	localparam logic [2:0] ST_INTERP = 3'd4;
	localparam logic [2:0] ST_EMIT   = 3'd5;

	localparam spp_pkg::sine_tab_t SINE_Q15 = spp_pkg::build_sine();
	localparam logic [IP_W-1:0]    IP_HALF  = IP_W'(1) << (FRAC_W - 1);

	function automatic logic signed [SMP_W-1:0] scale_sample(
		input logic signed [SMP_W-1:0] s,
		input logic [GAIN_W-1:0]       g
	);
		logic signed [2*SMP_W+1:0] v;
		logic signed [SMP_W+2:0]   q;
		v = s * $signed({1'b0, g}) + 34'sd16384;
		q = v[2*SMP_W+1:FRAC_W];
		if (q > (SMP_W+3)'(spp_pkg::SAMPLE_MAX)) begin
			return spp_pkg::SAMPLE_MAX;
		end else if (q < (SMP_W+3)'(spp_pkg::SAMPLE_MIN)) begin
			return spp_pkg::SAMPLE_MIN;
		end
		return q[SMP_W-1:0];
	endfunction

	logic [2:0]                    state_q;
	logic signed [PAN_W-1:0]       pan_q;
	logic signed [PAN_W-1:0]       last_q;
	logic signed [PAN_W-1:0]       manual_q;
	logic signed [PAN_W-1:0]       adjust_q;
	logic                          flag_q;
	logic [GAIN_W-1:0]             gain_q [2];

	logic signed [PAN_W-1:0]       tgt_q;
	logic [spp_pkg::RATE_W-1:0]    up_rate_q;
	logic [spp_pkg::RATE_W-1:0]    down_rate_q;
	logic [spp_pkg::N_W-1:0]       frames_q;
	logic [AMT_W-1:0]              up_amt_q;
	logic [AMT_W-1:0]              down_amt_q;
	logic [GAIN_W-1:0]             ga_q [2];
	logic [GAIN_W-1:0]             gd_q [2];
	logic [FRAC_W-1:0]             gf_q [2];

	logic                          out_valid_q;
	logic signed [SMP_W-1:0]       left_q;
	logic signed [SMP_W-1:0]       right_q;
	logic signed [PAN_W-1:0]       pan_out_q;
	logic                          fv_q;

	logic                          out_free;
	logic                          emit_item;
	logic                          emit_buf;

	logic signed [SLEW_W-1:0]      cur_w;
	logic signed [SLEW_W-1:0]      tgt_w;
	logic signed [SLEW_W-1:0]      hi_w;
	logic signed [SLEW_W-1:0]      lo_w;
	logic signed [SLEW_W-1:0]      nxt_w;
	logic signed [SLEW_W-1:0]      one_w;
	logic signed [PAN_W-1:0]       slewed;

	logic [PAN_W-1:0]              pos [2];
	logic [IDX_W-1:0]              lk_idx [2];
	logic [IDX_W-1:0]              lk_nidx [2];
	logic [GAIN_W-1:0]             lk_a [2];
	logic [GAIN_W-1:0]             lk_b [2];
	logic [IP_W-1:0]               ip [2];
	logic [GAIN_W-1:0]             gain_new [2];

	assign out_free  = !out_valid_q || !out_stall;
	assign pop       = (state_q == ST_IDLE) && !q_stat.empty &&
	                   ((item.kind == spp_pkg::KIND_BUFFER) || out_free);
	assign emit_item = pop && (item.kind != spp_pkg::KIND_BUFFER);
	assign emit_buf  = (state_q == ST_EMIT) && out_free;

	assign out_valid   = out_valid_q;
	assign left_out    = left_q;
	assign right_out   = right_q;
	assign pan_now     = pan_out_q;
	assign frame_valid = fv_q;

	// slew toward the target, then clamp to the pan range
	always_comb begin
		cur_w = SLEW_W'(pan_q);
		tgt_w = SLEW_W'(tgt_q);
		one_w = SLEW_W'(spp_pkg::PAN_ONE);
		hi_w  = cur_w + $signed(SLEW_W'(up_amt_q));
		lo_w  = cur_w - $signed(SLEW_W'(down_amt_q));
		if (hi_w < tgt_w) begin
			nxt_w = hi_w;
		end else if (lo_w > tgt_w) begin
			nxt_w = lo_w;
		end else begin
			nxt_w = tgt_w;
		end
		if (nxt_w > one_w) begin
			slewed = spp_pkg::PAN_ONE;
		end else if (nxt_w < -one_w) begin
			slewed = -spp_pkg::PAN_ONE;
		end else begin
			slewed = nxt_w[PAN_W-1:0];
		end
	end

	// table read for both lanes, left angle mirrors the right one
	always_comb begin
		pos[LANE_LEFT]  = $unsigned(spp_pkg::PAN_ONE - pan_q);
		pos[LANE_RIGHT] = $unsigned(pan_q + spp_pkg::PAN_ONE);
		for (int i = 0; i < 2; i++) begin
			lk_idx[i]  = pos[i][PAN_W-1:FRAC_W];
			lk_nidx[i] = (lk_idx[i] == IDX_W'(spp_pkg::SINE_ENTRIES)) ?
			             lk_idx[i] : lk_idx[i] + 1'b1;
			lk_a[i]    = SINE_Q15[lk_idx[i]];
			lk_b[i]    = SINE_Q15[lk_nidx[i]];
			ip[i]      = IP_W'(gd_q[i]) * IP_W'(gf_q[i]);
			gain_new[i] = ga_q[i] + GAIN_W'((ip[i] + IP_HALF) >> FRAC_W);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q           <= ST_IDLE;
			pan_q             <= '0;
			last_q            <= '0;
			manual_q          <= '0;
			adjust_q          <= '0;
			flag_q            <= 1'b0;
			gain_q[LANE_LEFT]  <= spp_pkg::GAIN_RESET;
			gain_q[LANE_RIGHT] <= spp_pkg::GAIN_RESET;
			out_valid_q       <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (pop) begin
						case (item.kind)
							spp_pkg::KIND_SET_MANUAL: begin
								manual_q <= item.pan;
								last_q   <= item.pan;
							end
							spp_pkg::KIND_SET_ADJUST: begin
								adjust_q <= item.pan;
								last_q   <= item.pan;
							end
							spp_pkg::KIND_SET_FLAG: flag_q  <= item.flag;
							spp_pkg::KIND_BUFFER:   state_q <= ST_MUL;
							default: ;
						endcase
					end
				end
				ST_MUL:    state_q <= ST_SLEW;
				ST_SLEW: begin
					pan_q   <= slewed;
					state_q <= ST_LOOK;
				end
				ST_LOOK:   state_q <= ST_INTERP;
				ST_INTERP: begin
					gain_q[LANE_LEFT]  <= gain_new[LANE_LEFT];
					gain_q[LANE_RIGHT] <= gain_new[LANE_RIGHT];
					state_q            <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default:   state_q <= ST_IDLE;
			endcase
			if (emit_item || emit_buf) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && (item.kind == spp_pkg::KIND_BUFFER)) begin
			frames_q <= item.frames;
			if (last_q != manual_q) begin
				if (flag_q) begin
					tgt_q       <= adjust_q;
					up_rate_q   <= rates.decay;
					down_rate_q <= rates.attack;
				end else begin
					tgt_q       <= manual_q;
					up_rate_q   <= rates.decay;
					down_rate_q <= rates.decay;
				end
			end else begin
				tgt_q       <= manual_q;
				up_rate_q   <= rates.manual_fade;
				down_rate_q <= rates.manual_fade;
			end
		end
		if (state_q == ST_MUL) begin
			up_amt_q   <= AMT_W'(up_rate_q) * AMT_W'(frames_q);
			down_amt_q <= AMT_W'(down_rate_q) * AMT_W'(frames_q);
		end
		if (state_q == ST_LOOK) begin
			for (int i = 0; i < 2; i++) begin
				ga_q[i] <= lk_a[i];
				gd_q[i] <= (lk_b[i] > lk_a[i]) ? lk_b[i] - lk_a[i] : '0;
				gf_q[i] <= pos[i][FRAC_W-1:0];
			end
		end
		if (emit_item) begin
			pan_out_q <= pan_q;
			if (item.kind == spp_pkg::KIND_FRAME) begin
				left_q  <= scale_sample(item.left, gain_q[LANE_LEFT]);
				right_q <= scale_sample(item.right, gain_q[LANE_RIGHT]);
				fv_q    <= 1'b1;
			end else begin
				left_q  <= '0;
				right_q <= '0;
				fv_q    <= 1'b0;
			end
		end else if (emit_buf) begin
			pan_out_q <= pan_q;
			left_q    <= '0;
			right_q   <= '0;
			fv_q      <= 1'b0;
		end
	end

endmodule

@@ rtl/slewed_constant_power_panner.sv @@
// ----------------------------------------------------------------------------
// slewed_constant_power_panner
// stereo panner with a slew-limited Q22 pan position and a constant-power
// cos/sin gain law taken from a quarter-sine table
// ----------------------------------------------------------------------------
// Every request gives exactly one result. Set-target, set-flag, frame and
// unknown requests pass at one per clock unless the output or a buffer start
// stalls them, through the input register, queue and result register. A
// buffer-start request holds the executing side through queue pop, rate times
// frame-count multiply, slew and clamp, sine table read, interpolation and
// result; requests arriving meanwhile collect in the queue (QUEUE_DEPTH
// entries) behind the input register. Frames after a buffer start use the
// gains it latched. The rate registers sit at byte addresses 0, 4 and 8; the
// user must write them only while no request is in flight; nothing enforces it.
module slewed_constant_power_panner #(
	parameter int QUEUE_DEPTH = spp_pkg::QUEUE_DEPTH
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   psel,
	input  logic                                   penable,
	input  logic                                   pwrite,
	input  logic [spp_pkg::ADDR_W-1:0]             paddr,
	input  logic [spp_pkg::DATA_W-1:0]             pwdata,
	output logic [spp_pkg::DATA_W-1:0]             prdata,
	output logic                                   pready,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic [2:0]                             func,
	input  logic signed [spp_pkg::PAN_W-1:0]       pan_value,
	input  logic                                   adjust_on,
	input  logic [spp_pkg::N_W-1:0]                frame_count,
	input  logic signed [spp_pkg::SAMPLE_W-1:0]    left_in,
	input  logic signed [spp_pkg::SAMPLE_W-1:0]    right_in,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic signed [spp_pkg::SAMPLE_W-1:0]    left_out,
	output logic signed [spp_pkg::SAMPLE_W-1:0]    right_out,
	output logic signed [spp_pkg::PAN_W-1:0]       pan_now,
	output logic                                   frame_valid
);

	logic [spp_pkg::RATE_W-1:0] manual_fade_q;
	logic [spp_pkg::RATE_W-1:0] attack_q;
	logic [spp_pkg::RATE_W-1:0] decay_q;
	logic [1:0]                 reg_idx;
	logic                       reg_wr;
	spp_pkg::rates_t            rates;

	logic                       q_push;
	logic                       q_pop;
	spp_pkg::item_t             q_wr_item;
	spp_pkg::item_t             q_rd_item;
	spp_pkg::q_stat_t           q_stat;

	assign pready  = 1'b1;
	assign reg_idx = paddr[spp_pkg::ADDR_W-1:2];
	assign reg_wr  = psel && penable && pwrite && pready;

	assign rates.manual_fade = manual_fade_q;
	assign rates.attack      = attack_q;
	assign rates.decay       = decay_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			manual_fade_q <= spp_pkg::MANUAL_FADE_RESET;
			attack_q      <= spp_pkg::ATTACK_RESET;
			decay_q       <= spp_pkg::DECAY_RESET;
		end else if (reg_wr) begin
			case (reg_idx)
				spp_pkg::REG_MANUAL_FADE: manual_fade_q <= pwdata[spp_pkg::RATE_W-1:0];
				spp_pkg::REG_ATTACK:      attack_q      <= pwdata[spp_pkg::RATE_W-1:0];
				spp_pkg::REG_DECAY:       decay_q       <= pwdata[spp_pkg::RATE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			spp_pkg::REG_MANUAL_FADE: prdata = spp_pkg::DATA_W'(manual_fade_q);
			spp_pkg::REG_ATTACK:      prdata = spp_pkg::DATA_W'(attack_q);
			spp_pkg::REG_DECAY:       prdata = spp_pkg::DATA_W'(decay_q);
			default:                  prdata = '0;
		endcase
	end

	spp_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.func        (func),
		.pan_value   (pan_value),
		.adjust_on   (adjust_on),
		.frame_count (frame_count),
		.left_in     (left_in),
		.right_in    (right_in),
		.q_stat      (q_stat),
		.push        (q_push),
		.item        (q_wr_item)
	);

	spp_queue #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.wr_item (q_wr_item),
		.pop     (q_pop),
		.rd_item (q_rd_item),
		.stat    (q_stat)
	);

	spp_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.rates       (rates),
		.q_stat      (q_stat),
		.item        (q_rd_item),
		.pop         (q_pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.left_out    (left_out),
		.right_out   (right_out),
		.pan_now     (pan_now),
		.frame_valid (frame_valid)
	);

	// pan never leaves the clamped range
	a_pan_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (pan_now <= spp_pkg::PAN_ONE && pan_now >= -spp_pkg::PAN_ONE))
		else $error("pan result outside clamp range");

	// only frame results carry samples
	a_nonframe_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !frame_valid) |-> (left_out == '0 && right_out == '0))
		else $error("non-frame result carries samples");

	// the executing side never pops an empty queue
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_stat.empty)
		else $error("queue popped while empty");

	// a request waiting at the front while the queue is full is held off
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (q_stat.full && !q_push))
		else $error("input stalled without a full queue");

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the slewed constant-power panner against a behavioural predictor:
// a directed table of edge cases, then four random phases with different rate
// settings and idling patterns, including a long output hold-off that backs
// the request path up. Every result is compared field by field in order.
// ----------------------------------------------------------------------------
module testbench;

	import spp_pkg::*;

	localparam int              LIMIT_CYCLES     = 200000;
	localparam int              PHASE_ITEMS      = 200;
	localparam int              HOLD_CYCLES      = 80;
	localparam int              DIRECTED_N       = 25;
	localparam longint unsigned QUARTER_TURN_Q30 = 64'd1686629713;
	localparam longint          PAN_UNITY        = longint'(1) << PAN_FRAC_BITS;

	localparam logic [2:0] FUNC_UNUSED_LO  = 3'd5;
	localparam logic [2:0] FUNC_UNUSED_MID = 3'd6;
	localparam logic [2:0] FUNC_UNUSED_HI  = 3'd7;

	localparam logic signed [PAN_W-1:0] FULL_RIGHT = PAN_W'(1 << PAN_FRAC_BITS);
	localparam logic signed [PAN_W-1:0] FULL_LEFT  = -FULL_RIGHT;
	localparam logic signed [PAN_W-1:0] PAN_TOP    = 24'sh7fffff;
	localparam logic signed [PAN_W-1:0] PAN_BOTTOM = 24'sh800000;

	typedef struct packed {
		logic [2:0]                 func;
		logic signed [PAN_W-1:0]    pan;
		logic                       adjust;
		logic [N_W-1:0]             frames;
		logic signed [SAMPLE_W-1:0] left;
		logic signed [SAMPLE_W-1:0] right;
	} pan_request_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] left;
		logic signed [SAMPLE_W-1:0] right;
		logic signed [PAN_W-1:0]    pan;
		logic                       frame;
	} pan_result_t;

	typedef struct packed {
		pan_request_t req;
		logic         typed;
		pan_result_t  want;
	} directed_row_t;

	// typed rows carry a result that is plain from the request alone
	localparam directed_row_t DIRECTED_ROWS [0:DIRECTED_N-1] = '{
		'{'{FUNC_FRAME, 24'sd0, 1'b0, 13'd0, 16'sd0, 16'sd0}, 1'b1,
			'{16'sd0, 16'sd0, 24'sd0, 1'b1}},
		'{'{FUNC_UNUSED_LO, 24'sh123456, 1'b1, 13'h1fff, -16'sd1, 16'sd1}, 1'b1,
			'{16'sd0, 16'sd0, 24'sd0, 1'b0}},
		'{'{FUNC_UNUSED_HI, PAN_TOP, 1'b1, 13'd4096, 16'sh7fff, 16'sh8000}, 1'b1,
			'{16'sd0, 16'sd0, 24'sd0, 1'b0}},
		'{'{FUNC_FRAME, 24'sd0, 1'b0, 13'd0, 16'sh7fff, 16'sh8000}, 1'b0, '0},
		'{'{FUNC_FRAME, 24'sd0, 1'b1, 13'd0, 16'sh8000, 16'sh7fff}, 1'b0, '0},
		'{'{FUNC_SET_MANUAL, PAN_TOP, 1'b0, 13'd0, 16'sd0, 16'sd0}, 1'b1,
			'{16'sd0, 16'sd0, 24'sd0, 1'b0}},
		'{'{FUNC_BUFFER, 24'sd0, 1'b0, 13'd4096, 16'sd0, 16'sd0}, 1'b1,
			'{16'sd0, 16'sd0, FULL_RIGHT, 1'b0}},
		'{'{FUNC_FRAME, 24'sd0, 1'b0, 13'd0, 16'sh7fff, 16'sd0}, 1'b1,
			'{16'sd0, 16'sd0, FULL_RIGHT, 1'b1}},
		'{'{FUNC_FRAME, 24'sd0, 1'b0, 13'd0, 16'sh8000, 16'sh8000}, 1'b0, '0},
		'{'{FUNC_SET_MANUAL, FULL_LEFT, 1'b0, 13'd0, 16'sd0, 16'sd0}, 1'b1,
			'{16'sd0, 16'sd0, FULL_RIGHT, 1'b0}},
		'{'{FUNC_BUFFER, 24'sd0, 1'b0, 13'h1fff, 16'sd0, 16'sd0}, 1'b1,
			'{16'sd0, 16'sd0, FULL_LEFT, 1'b0}},
		'{'{FUNC_FRAME, 24'sd0, 1'b0, 13'd0, 16'sh7fff, 16'sh7fff}, 1'b0, '0},
		'{'{FUNC_SET_FLAG, 24'sd0, 1'b1, 13'd0, 16'sd0, 16'sd0}, 1'b1,
			'{16'sd0, 16'sd0, FULL_LEFT, 1'b0}},
		'{'{FUNC_SET_ADJUST, FULL_RIGHT, 1'b0, 13'd0, 16'sd0, 16'sd0}, 1'b1,
			'{16'sd0, 16'sd0, FULL_LEFT, 1'b0}},
		'{'{FUNC_BUFFER, 24'sd0, 1'b0, 13'd1, 16'sd0, 16'sd0}, 1'b0, '0},
		'{'{FUNC_BUFFER, 24'sd0, 1'b0, 13'd0, 16'sd0, 16'sd0}, 1'b0, '0},
		'{'{FUNC_SET_ADJUST, PAN_BOTTOM, 1'b0, 13'd0, 16'sd0, 16'sd0}, 1'b0, '0},
		'{'{FUNC_BUFFER, 24'sd0, 1'b0, 13'd100, 16'sd0, 16'sd0}, 1'b0, '0},
		'{'{FUNC_SET_FLAG, 24'sd0, 1'b0, 13'd0, 16'sd0, 16'sd0}, 1'b0, '0},
		'{'{FUNC_BUFFER, 24'sd0, 1'b0, 13'd4096, 16'sd0, 16'sd0}, 1'b0, '0},
		'{'{FUNC_FRAME, 24'sd0, 1'b0, 13'd0, 16'sd12345, -16'sd12345}, 1'b0, '0},
		'{'{FUNC_SET_MANUAL, 24'sd0, 1'b0, 13'd0, 16'sd0, 16'sd0}, 1'b0, '0},
		'{'{FUNC_BUFFER, 24'sd0, 1'b0, 13'd60, 16'sd0, 16'sd0}, 1'b0, '0},
		'{'{FUNC_UNUSED_MID, 24'sd0, 1'b1, 13'd5, 16'sd7, 16'sd9}, 1'b0, '0},
		'{'{FUNC_FRAME, 24'sd0, 1'b0, 13'd0, -16'sd1, 16'sd1}, 1'b0, '0}
	};

	logic                       clk;
	logic                       arst_n;
	logic                       psel;
	logic                       penable;
	logic                       pwrite;
	logic [ADDR_W-1:0]          paddr;
	logic [DATA_W-1:0]          pwdata;
	logic [DATA_W-1:0]          prdata;
	logic                       pready;
	logic                       in_valid;
	logic                       in_stall;
	logic [2:0]                 func;
	logic signed [PAN_W-1:0]    pan_value;
	logic                       adjust_on;
	logic [N_W-1:0]             frame_count;
	logic signed [SAMPLE_W-1:0] left_in;
	logic signed [SAMPLE_W-1:0] right_in;
	logic                       out_valid;
	logic                       out_stall;
	logic signed [SAMPLE_W-1:0] left_out;
	logic signed [SAMPLE_W-1:0] right_out;
	logic signed [PAN_W-1:0]    pan_now;
	logic                       frame_valid;

	// predictor state
	logic [GAIN_W-1:0] gain_lut [0:SINE_ENTRIES];
	logic [RATE_W-1:0] pan_rate [0:2];
	longint            pan_pos;
	longint            tgt_last;
	longint            tgt_manual;
	longint            tgt_adjust;
	logic              adjust_mode;
	longint            gain_l;
	longint            gain_r;

	pan_result_t pending_results [$];
	int          error_count;
	int          cycle_count;
	int          send_idle_pct;
	int          recv_stall_pct;
	int          hold_left;
	bit          hold_armed;
	bit          hold_done;

	slewed_constant_power_panner DUT (.*);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	task automatic report_mismatch(input string what, input longint got, input longint want);
		error_count++;
		if (error_count <= 100) begin
			$display("%0t mismatch %s: got %0d, want %0d", $realtime, what, got, want);
		end
	endtask

	// quarter sine in q15 from a q30 taylor series, rounded half up
	function automatic void fill_gain_lut();
		longint unsigned x;
		longint unsigned x2;
		longint unsigned term;
		longint unsigned dv;
		longint          acc;
		for (int k = 0; k <= SINE_ENTRIES; k++) begin
			x = (longint'(k) * QUARTER_TURN_Q30 + SINE_ENTRIES / 2) / SINE_ENTRIES;
			x2 = (x * x) >> 30;
			term = x;
			acc = longint'(x);
			for (int n = 1; n <= 7; n++) begin
				dv = longint'(2 * n * (2 * n + 1));
				term = ((term * x2) >> 30) / dv;
				acc = (n % 2 == 1) ? acc - longint'(term) : acc + longint'(term);
			end
			if (acc < 0) begin
				acc = 0;
			end
			acc = (acc + 16384) >> 15;
			gain_lut[k] = (acc > 32768) ? GAIN_W'(32768) : GAIN_W'(acc);
		end
	endfunction

	function automatic longint quarter_sine(input longint pos);
		longint span_mask;
		longint scaled;
		longint idx;
		longint fr;
		longint lo;
		longint hi;
		span_mask = (longint'(1) << (PAN_FRAC_BITS + 1)) - 1;
		scaled = pos * SINE_ENTRIES;
		idx = scaled >> (PAN_FRAC_BITS + 1);
		fr = scaled & span_mask;
		if (idx >= SINE_ENTRIES) begin
			return longint'(gain_lut[SINE_ENTRIES]);
		end
		lo = longint'(gain_lut[idx]);
		hi = longint'(gain_lut[idx + 1]);
		if (hi < lo) begin
			hi = lo;
		end
		return lo + (((hi - lo) * fr + (longint'(1) << PAN_FRAC_BITS)) >> (PAN_FRAC_BITS + 1));
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] apply_gain(input longint s, input longint g);
		longint q;
		q = (s * g + 16384) >>> 15;
		if (q > 32767) begin
			q = 32767;
		end
		if (q < -32768) begin
			q = -32768;
		end
		return SAMPLE_W'(q);
	endfunction

	function automatic void reset_panner();
		pan_rate[REG_MANUAL_FADE] = MANUAL_FADE_RESET;
		pan_rate[REG_ATTACK] = ATTACK_RESET;
		pan_rate[REG_DECAY] = DECAY_RESET;
		pan_pos = 0;
		tgt_last = 0;
		tgt_manual = 0;
		tgt_adjust = 0;
		adjust_mode = 1'b0;
		gain_l = 23170;
		gain_r = 23170;
	endfunction

	// move the pan toward its target for one buffer and latch the gains
	function automatic void start_buffer(input longint frames);
		longint n;
		longint tgt;
		longint up;
		longint dn;
		n = (frames > MAX_BUFFER_FRAMES) ? MAX_BUFFER_FRAMES : frames;
		tgt = tgt_manual;
		if (tgt_last != tgt_manual) begin
			if (adjust_mode) begin
				tgt = tgt_adjust;
				up = longint'(pan_rate[REG_DECAY]) * n;
				dn = longint'(pan_rate[REG_ATTACK]) * n;
			end else begin
				up = longint'(pan_rate[REG_DECAY]) * n;
				dn = up;
			end
		end else begin
			up = longint'(pan_rate[REG_MANUAL_FADE]) * n;
			dn = up;
		end
		if (pan_pos < tgt - up) begin
			pan_pos = pan_pos + up;
		end else if (pan_pos > tgt + dn) begin
			pan_pos = pan_pos - dn;
		end else begin
			pan_pos = tgt;
		end
		if (pan_pos > PAN_UNITY) begin
			pan_pos = PAN_UNITY;
		end
		if (pan_pos < -PAN_UNITY) begin
			pan_pos = -PAN_UNITY;
		end
		gain_r = quarter_sine(pan_pos + PAN_UNITY);
		gain_l = quarter_sine(PAN_UNITY - pan_pos);
	endfunction

	function automatic pan_result_t apply_request(input pan_request_t r);
		pan_result_t res;
		res = '0;
		case (r.func)
			FUNC_SET_MANUAL: begin
				tgt_manual = longint'(r.pan);
				tgt_last = tgt_manual;
			end
			FUNC_SET_ADJUST: begin
				tgt_adjust = longint'(r.pan);
				tgt_last = tgt_adjust;
			end
			FUNC_SET_FLAG: begin
				adjust_mode = r.adjust;
			end
			FUNC_BUFFER: begin
				start_buffer(longint'(r.frames));
			end
			FUNC_FRAME: begin
				res.left = apply_gain(longint'(r.left), gain_l);
				res.right = apply_gain(longint'(r.right), gain_r);
				res.frame = 1'b1;
			end
			default: begin
			end
		endcase
		res.pan = PAN_W'(pan_pos);
		return res;
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] make_sample();
		case ($urandom_range(9))
			0: return 16'sh7fff;
			1: return 16'sh8000;
			2: return ($urandom_range(1) == 1) ? -16'sd1 : 16'sd0;
			default: return SAMPLE_W'($urandom);
		endcase
	endfunction

	function automatic pan_request_t make_request();
		pan_request_t r;
		int           pick;
		pick = $urandom_range(99);
		if (pick < 45) begin
			r.func = FUNC_FRAME;
		end else if (pick < 63) begin
			r.func = FUNC_BUFFER;
		end else if (pick < 74) begin
			r.func = FUNC_SET_MANUAL;
		end else if (pick < 85) begin
			r.func = FUNC_SET_ADJUST;
		end else if (pick < 96) begin
			r.func = FUNC_SET_FLAG;
		end else begin
			r.func = 3'($urandom_range(FUNC_UNUSED_LO, FUNC_UNUSED_HI));
		end
		pick = $urandom_range(9);
		if (pick == 0) begin
			r.pan = PAN_W'($urandom);
		end else if (pick == 1) begin
			r.pan = ($urandom_range(1) == 1) ? FULL_RIGHT : FULL_LEFT;
		end else begin
			r.pan = PAN_W'($urandom_range(0, 2 * (1 << PAN_FRAC_BITS))) - FULL_RIGHT;
		end
		r.adjust = 1'($urandom);
		pick = $urandom_range(9);
		if (pick < 7) begin
			r.frames = N_W'($urandom_range(0, 64));
		end else if (pick < 9) begin
			r.frames = N_W'($urandom_range(0, MAX_BUFFER_FRAMES));
		end else begin
			r.frames = N_W'($urandom_range(MAX_BUFFER_FRAMES + 1, (1 << N_W) - 1));
		end
		r.left = make_sample();
		r.right = make_sample();
		return r;
	endfunction

	task automatic offer(input pan_request_t r, input logic typed, input pan_result_t want);
		pan_result_t predicted;
		while ($urandom_range(99) < send_idle_pct) begin
			@(negedge clk);
			in_valid = 1'b0;
			@(posedge clk);
		end
		@(negedge clk);
		func = r.func;
		pan_value = r.pan;
		adjust_on = r.adjust;
		frame_count = r.frames;
		left_in = r.left;
		right_in = r.right;
		in_valid = 1'b1;
		do @(posedge clk); while (in_stall);
		predicted = apply_request(r);
		pending_results.push_back(typed ? want : predicted);
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid = 1'b0;
		while (pending_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (6) @(posedge clk);
	endtask

	task automatic write_rate(input logic [1:0] idx, input logic [RATE_W-1:0] value);
		logic [DATA_W-1:0] readback;
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = {idx, 2'b00};
		pwdata = DATA_W'(value);
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		pwrite = 1'b0;
		penable = 1'b0;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		readback = prdata;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pan_rate[idx] = value;
		if (readback[RATE_W-1:0] !== value) begin
			report_mismatch("rate readback", longint'(readback), longint'(value));
		end
	endtask

	task automatic run_phase(input int send_pct, input int recv_pct,
			input logic [RATE_W-1:0] fade, input logic [RATE_W-1:0] att,
			input logic [RATE_W-1:0] dcy, input bit with_hold);
		int           counted;
		pan_request_t r;
		counted = 0;
		write_rate(REG_MANUAL_FADE, fade);
		write_rate(REG_ATTACK, att);
		write_rate(REG_DECAY, dcy);
		send_idle_pct = send_pct;
		recv_stall_pct = recv_pct;
		while (counted < PHASE_ITEMS) begin
			if (with_hold && counted == PHASE_ITEMS / 4) begin
				hold_armed = 1'b1;
			end
			r = make_request();
			offer(r, 1'b0, '0);
			if (r.func <= FUNC_FRAME) begin
				counted++;
			end
		end
		drain();
	endtask

	// output side: random stalls plus one long hold-off when armed
	always @(negedge clk) begin
		if (hold_armed && !hold_done) begin
			hold_left = HOLD_CYCLES;
			hold_done = 1'b1;
		end
		if (hold_left > 0) begin
			out_stall = 1'b1;
			hold_left--;
		end else begin
			out_stall = ($urandom_range(99) < recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		pan_result_t want;
		if (out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				report_mismatch("result with nothing pending", longint'(pan_now), 0);
			end else begin
				want = pending_results.pop_front();
				if (left_out !== want.left) begin
					report_mismatch("left_out", longint'(left_out), longint'(want.left));
				end
				if (right_out !== want.right) begin
					report_mismatch("right_out", longint'(right_out), longint'(want.right));
				end
				if (pan_now !== want.pan) begin
					report_mismatch("pan_now", longint'(pan_now), longint'(want.pan));
				end
				if (frame_valid !== want.frame) begin
					report_mismatch("frame_valid", longint'(frame_valid), longint'(want.frame));
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("testbench: done, errors");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		func = FUNC_SET_MANUAL;
		pan_value = '0;
		adjust_on = 1'b0;
		frame_count = '0;
		left_in = '0;
		right_in = '0;
		out_stall = 1'b0;
		error_count = 0;
		cycle_count = 0;
		hold_left = 0;
		hold_armed = 1'b0;
		hold_done = 1'b0;
		send_idle_pct = 20;
		recv_stall_pct = 64;
		fill_gain_lut();
		reset_panner();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (int i = 0; i < DIRECTED_N; i++) begin
			offer(DIRECTED_ROWS[i].req, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
		end
		drain();

		run_phase(20, 64, RATE_W'($urandom_range(0, 200000)),
			RATE_W'($urandom_range(0, 50000)), RATE_W'($urandom_range(0, 50000)), 1'b0);
		run_phase(64, 20, '1, '1, '1, 1'b0);
		run_phase(0, 0, '0, '1, RATE_W'($urandom_range(1, 20000)), 1'b1);
		run_phase(0, 0, RATE_W'($urandom), '0, '0, 1'b0);

		repeat (10) @(posedge clk);
		if (error_count == 0) begin
			$display("testbench: done, clean");
		end else begin
			$display("testbench: done, errors");
		end
		$finish;
	end

endmodule
